// ===== hdl/olia_pkg.sv =====
// ----------------------------------------------------------------------------
// olia_pkg: shared types and constants for the ordered list unit
// Opcodes, sequencer states, default sizes and the result-load struct.
// ----------------------------------------------------------------------------
package olia_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_VALUE_BITS  = 16;
  localparam int FIELD_BITS      = 16;
  localparam int OP_BITS         = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_START  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DUMP   = 2'd2,
    OP_UNUSED = 2'd3
  } olia_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_TAIL,
    ST_DEL_SCAN,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_NONE,
    ST_EMIT_HOLD
  } olia_state_t;

  typedef struct packed {
    logic load;
    logic last;
    logic empty;
    logic overflow;
  } olia_emit_t;

endpackage

// ===== hdl/olia_store.sv =====
// ----------------------------------------------------------------------------
// olia_store: list entry memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module olia_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/olia_ctrl.sv =====
// ----------------------------------------------------------------------------
// olia_ctrl: list sequencer with shared equality compare
// Scans the entry memory one word per cycle for insert and delete, and steps
// the memory reads for the result stream.
// ----------------------------------------------------------------------------
module olia_ctrl
  import olia_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [OP_BITS-1:0]    opcode,
  input  logic [FIELD_BITS-1:0] item_value,
  input  logic [FIELD_BITS-1:0] anchor_value,
  output logic                  in_stall,
  input  logic                  out_accept,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [VALUE_BITS-1:0] mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  logic [VALUE_BITS-1:0] mem_rdata,
  output olia_emit_t            emit
);

  olia_state_t           state, state_next;
  logic [CW-1:0]         count;
  logic                  overflow;
  logic [CW-1:0]         idx;
  logic                  proc_valid;
  logic [AW-1:0]         proc_idx;
  logic                  found;
  logic [VALUE_BITS-1:0] carry;
  logic [VALUE_BITS-1:0] key;
  logic [CW-1:0]         wr;
  logic [AW-1:0]         emit_idx;

  logic [VALUE_BITS-1:0] item_in;
  logic [VALUE_BITS-1:0] anchor_in;
  olia_op_t              op;
  logic                  cmp_eq;
  logic                  issue;
  logic                  scan_done;
  logic                  emit_last;
  logic                  list_full;

  assign item_in   = VALUE_BITS'(item_value);
  assign anchor_in = VALUE_BITS'(anchor_value);
  assign op        = olia_op_t'(opcode);
  assign cmp_eq    = (mem_rdata == key);
  assign issue     = (idx != count);
  assign scan_done = !issue && !proc_valid;
  assign emit_last = (count == '0) || ((CW'(emit_idx) + CW'(1)) == count);
  assign list_full = (count == CW'(MAX_ENTRIES));
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            OP_INSERT: state_next = list_full ? ST_IDLE : ST_INS_SCAN;
            OP_DUMP:   state_next = ST_DEL_SCAN;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_SCAN:  if (scan_done) state_next = ST_INS_TAIL;
      ST_INS_TAIL:  state_next = ST_IDLE;
      ST_DEL_SCAN: begin
        if (scan_done) state_next = (wr == '0) ? ST_EMIT_NONE : ST_EMIT_READ;
      end
      ST_EMIT_READ: state_next = ST_EMIT_LOAD;
      ST_EMIT_LOAD: state_next = ST_EMIT_HOLD;
      ST_EMIT_NONE: state_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (out_accept) state_next = emit_last ? ST_IDLE : ST_EMIT_READ;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = idx[AW-1:0];
    emit          = '0;
    emit.overflow = overflow;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (op == OP_START)) begin
          mem_we    = 1'b1;
          mem_wdata = item_in;
        end
      end
      ST_INS_SCAN: begin
        if (proc_valid && found) begin
          mem_we    = 1'b1;
          mem_waddr = proc_idx;
          mem_wdata = carry;
        end
      end
      ST_INS_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = count[AW-1:0];
        mem_wdata = carry;
      end
      ST_DEL_SCAN: begin
        if (proc_valid && !cmp_eq) begin
          mem_we    = 1'b1;
          mem_waddr = wr[AW-1:0];
          mem_wdata = mem_rdata;
        end
      end
      ST_EMIT_READ: mem_raddr = emit_idx;
      ST_EMIT_LOAD: begin
        emit.load = 1'b1;
        emit.last = emit_last;
      end
      ST_EMIT_NONE: begin
        emit.load  = 1'b1;
        emit.last  = 1'b1;
        emit.empty = 1'b1;
      end
      ST_EMIT_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      overflow   <= 1'b0;
      proc_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          idx        <= '0;
          proc_valid <= 1'b0;
          found      <= 1'b0;
          wr         <= '0;
          emit_idx   <= '0;
          if (in_valid) begin
            case (op)
              OP_START: count <= CW'(1);
              OP_INSERT: begin
                if (list_full) overflow <= 1'b1;
                key   <= anchor_in;
                carry <= item_in;
              end
              OP_DUMP: key <= item_in;
              default: ;
            endcase
          end
        end
        ST_INS_SCAN, ST_DEL_SCAN: begin
          if (issue) idx <= idx + CW'(1);
          proc_valid <= issue;
          proc_idx   <= idx[AW-1:0];
          if (proc_valid) begin
            if (state == ST_INS_SCAN) begin
              if (found) carry <= mem_rdata;
              else if (cmp_eq) found <= 1'b1;
            end else if (!cmp_eq) begin
              wr <= wr + CW'(1);
            end
          end
          if ((state == ST_DEL_SCAN) && scan_done) count <= wr;
        end
        ST_INS_TAIL: count <= count + CW'(1);
        ST_EMIT_HOLD: begin
          if (out_accept && !emit_last) emit_idx <= emit_idx + AW'(1);
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_shift_after_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_SCAN) && mem_we |-> found)
    else $error("insert shift before anchor match");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEL_SCAN) |-> (wr <= idx))
    else $error("compaction write ahead of scan");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(overflow))
    else $error("overflow flag cleared outside reset");

endmodule

// ===== hdl/ordered_list_insert_after_delete_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_after_delete_unit: ordered list with insert and dump
// Keeps up to MAX_ENTRIES values in list order in a memory with one read and
// one write port.
//
// Input channel (in_valid / in_stall) takes one command word: start, insert
// after anchor, or delete-and-dump. in_stall is high while a command is at
// work, so one command is handled at a time.
// Start is handled in the idle state and does not raise in_stall. Insert scans
// the list one entry per cycle with the shared comparator and shifts the tail in
// the same pass. An insert into a full list is dropped and sets the sticky
// overflow flag. Dump compacts the list, then sends one result word per
// remaining entry (last_entry on the final one), or one word with list_empty
// set. Each entry word passes through memory read, load and hold; the empty
// word through load and hold.
// Results leave through an output register (out_valid / out_stall); while
// out_stall is high the word holds and the read sequence waits.
// Reset empties the list and clears the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_insert_after_delete_unit
  import olia_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_BITS-1:0]    opcode,
  input  logic [FIELD_BITS-1:0] item_value,
  input  logic [FIELD_BITS-1:0] anchor_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] entry_value,
  output logic                  last_entry,
  output logic                  list_empty,
  output logic                  overflow_seen
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  olia_emit_t            emit;
  logic                  out_accept;

  assign out_accept = out_valid && !out_stall;

  olia_store #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  olia_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .opcode       (opcode),
    .item_value   (item_value),
    .anchor_value (anchor_value),
    .in_stall     (in_stall),
    .out_accept   (out_accept),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .emit         (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      entry_value   <= emit.empty ? '0 : FIELD_BITS'(mem_rdata);
      last_entry    <= emit.last;
      list_empty    <= emit.empty;
      overflow_seen <= emit.overflow;
    end
  end

endmodule

// ===== tb/ordered_list_insert_after_delete_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_after_delete_unit_tb: self-checking bench for the list
// Sends start, insert and dump words and keeps its own copy of the list to
// predict every dump word. The bench compares each result word field by field
// in arrival order, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module ordered_list_insert_after_delete_unit_tb;
  import olia_pkg::*;

  localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
  localparam int VALUE_BITS  = DEF_VALUE_BITS;
  localparam logic [FIELD_BITS-1:0] VALUE_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - VALUE_BITS);
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic                  last;
    logic                  empty;
    logic                  ovf;
  } entry_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_BITS-1:0]    opcode = OP_UNUSED;
  logic [FIELD_BITS-1:0] item_value = '0;
  logic [FIELD_BITS-1:0] anchor_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIELD_BITS-1:0] entry_value;
  logic                  last_entry;
  logic                  list_empty;
  logic                  overflow_seen;

  logic [FIELD_BITS-1:0] list_vals [MAX_ENTRIES];
  int                    list_len = 0;
  logic                  list_ovf = 1'b0;
  entry_word_t           pending_entries [$];

  int fail_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  bit calm = 1'b0;

  ordered_list_insert_after_delete_unit #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .item_value   (item_value),
    .anchor_value (anchor_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_value  (entry_value),
    .last_entry   (last_entry),
    .list_empty   (list_empty),
    .overflow_seen(overflow_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic predict_list_op(input olia_op_t op, input logic [FIELD_BITS-1:0] val_in,
                                 input logic [FIELD_BITS-1:0] anc_in);
    logic [FIELD_BITS-1:0] val;
    logic [FIELD_BITS-1:0] anc;
    int pos;
    int wr;
    bit found;
    entry_word_t w;
    val = val_in & VALUE_MASK;
    anc = anc_in & VALUE_MASK;
    case (op)
      OP_START: begin
        list_vals[0] = val;
        list_len = 1;
      end
      OP_INSERT: begin
        if (list_len >= MAX_ENTRIES) begin
          list_ovf = 1'b1;
        end else begin
          pos = list_len;
          found = 1'b0;
          for (int i = 0; i < list_len; i++) begin
            if (!found && list_vals[i] == anc) begin
              pos = i + 1;
              found = 1'b1;
            end
          end
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      OP_DUMP: begin
        wr = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] != val) begin
            list_vals[wr] = list_vals[i];
            wr++;
          end
        end
        list_len = wr;
        if (wr == 0) begin
          w = '{value: '0, last: 1'b1, empty: 1'b1, ovf: list_ovf};
          pending_entries = {pending_entries, w};
        end else begin
          for (int i = 0; i < wr; i++) begin
            w = '{value: list_vals[i], last: (i == wr - 1), empty: 1'b0, ovf: list_ovf};
            pending_entries = {pending_entries, w};
          end
        end
      end
      default: ;
    endcase
  endtask

  // hold the word until it is taken, then advance the list copy
  task automatic send_word(input olia_op_t op, input logic [FIELD_BITS-1:0] val,
                           input logic [FIELD_BITS-1:0] anc);
    int gap;
    gap = (idle_on && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    opcode       <= op;
    item_value   <= val;
    anchor_value <= anc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_list_op(op, val, anc);
  endtask

  always @(negedge clk) begin
    if (calm || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    entry_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        $error("entry_value: expected no word, actual %h", entry_value);
        fail_count++;
      end else begin
        want = pending_entries.pop_front();
        if (entry_value !== want.value) begin
          $error("entry_value: expected %h, actual %h", want.value, entry_value);
          fail_count++;
        end
        if (last_entry !== want.last) begin
          $error("last_entry: expected %b, actual %b", want.last, last_entry);
          fail_count++;
        end
        if (list_empty !== want.empty) begin
          $error("list_empty: expected %b, actual %b", want.empty, list_empty);
          fail_count++;
        end
        if (overflow_seen !== want.ovf) begin
          $error("overflow_seen: expected %b, actual %b", want.ovf, overflow_seen);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [FIELD_BITS-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return FIELD_BITS'($urandom_range(0, 7));
    return FIELD_BITS'($urandom);
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_listed();
    if (list_len > 0 && $urandom_range(0, 3) != 0)
      return list_vals[$urandom_range(0, list_len - 1)];
    return pick_value();
  endfunction

  task automatic test_unstarted_list();
    send_word(OP_DUMP,   16'h1234, 16'h0000);
    send_word(OP_INSERT, 16'h0005, 16'h9999);
    send_word(OP_INSERT, 16'hFFFF, 16'h0005);
    send_word(OP_DUMP,   16'h0000, 16'hFFFF);
  endtask

  task automatic test_insert_order();
    send_word(OP_START,  16'h0010, 16'h0000);
    send_word(OP_INSERT, 16'h0020, 16'h0010);
    send_word(OP_INSERT, 16'h0015, 16'h0010);
    send_word(OP_INSERT, 16'h0030, 16'hABCD);
    send_word(OP_DUMP,   16'h0015, 16'h0000);
  endtask

  task automatic test_duplicates();
    send_word(OP_START,  16'h0007, 16'h0000);
    send_word(OP_INSERT, 16'h0007, 16'h0007);
    send_word(OP_INSERT, 16'h0009, 16'h0007);
    send_word(OP_INSERT, 16'h0007, 16'h0009);
    send_word(OP_DUMP,   16'h0007, 16'h0000);
    send_word(OP_DUMP,   16'h0009, 16'h0000);
    send_word(OP_DUMP,   16'h0009, 16'h0000);
  endtask

  task automatic test_extreme_values();
    send_word(OP_START,  16'hFFFF, 16'hFFFF);
    send_word(OP_INSERT, 16'h0000, 16'hFFFF);
    send_word(OP_INSERT, 16'hAAAA, 16'h0000);
    send_word(OP_INSERT, 16'h5555, 16'hFFFF);
    send_word(OP_DUMP,   16'h1111, 16'hFFFF);
  endtask

  task automatic test_unused_opcode();
    send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_word(OP_UNUSED, 16'h0000, 16'h0000);
    send_word(OP_DUMP,   16'h1234, 16'h0000);
  endtask

  task automatic test_random_lists();
    int sent;
    int n;
    olia_op_t op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          op = olia_op_t'($urandom_range(0, 3));
          send_word(op, pick_listed(), pick_listed());
          if (op != OP_UNUSED) sent++;
        end
        1: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) send_word(OP_INSERT, pick_value(), pick_value());
          send_word(OP_DUMP, pick_listed(), FIELD_BITS'($urandom));
          sent += n + 1;
        end
        default: begin
          send_word(OP_START, pick_value(), FIELD_BITS'($urandom));
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
          for (int i = 0; i < n; i++) send_word(OP_INSERT, pick_value(), pick_listed());
          sent += n + 1;
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) send_word(OP_DUMP, pick_listed(), FIELD_BITS'($urandom));
          sent += n;
        end
      endcase
    end
  endtask

  task automatic test_full_list();
    calm = 1'b1;
    send_word(OP_START, 16'h0001, 16'h0000);
    for (int i = 0; i < MAX_ENTRIES - 1; i++)
      send_word(OP_INSERT, FIELD_BITS'(i + 2), pick_listed());
    send_word(OP_INSERT, 16'hBEEF, 16'h0001);
    send_word(OP_INSERT, 16'hBEEF, 16'hFFFF);
    send_word(OP_DUMP,   16'hFFFF, 16'h0000);
    send_word(OP_DUMP,   16'h0001, 16'h0000);
    send_word(OP_INSERT, 16'hBEEF, 16'h0002);
    send_word(OP_DUMP,   16'h0000, 16'h0000);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unstarted_list();
    test_insert_order();
    test_duplicates();
    test_extreme_values();
    test_unused_opcode();
    test_random_lists();
    test_full_list();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/olia_pkg.sv
hdl/olia_store.sv
hdl/olia_ctrl.sv
hdl/ordered_list_insert_after_delete_unit.sv
tb/ordered_list_insert_after_delete_unit_tb.sv
